[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hges_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hges_pkg;

    localparam int TIME_W    = 32;
    localparam int CHARGE_W  = 11;
    localparam int RAW_W     = 16;
    localparam int SENSOR_W  = 14;
    localparam int COUNT_W   = 14;
    localparam int SUM_W     = 25;
    localparam int CFG_IDX_W = 2;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // earliest time before any in-gate hit
    localparam logic signed [TIME_W-1:0] MIN_TIME_INIT = 32'sd9999999;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_OFFSET = 2'd0,
        CFG_GATE_LOW    = 2'd1,
        CFG_GATE_HIGH   = 2'd2
    } t_cfg_index;

    // classified hit handed from front to back
    typedef struct packed {
        logic                     in_gate;
        logic signed [TIME_W-1:0] shifted_time;
        logic [CHARGE_W-1:0]      charge;
        logic [SENSOR_W-1:0]      sensor;
        logic                     last;
    } t_hit;

    // one result item
    typedef struct packed {
        logic                     in_gate;
        logic signed [TIME_W-1:0] shifted_time;
        logic [COUNT_W-1:0]       slot_index;
        logic                     event_end;
        logic [COUNT_W-1:0]       gate_hit_count;
        logic [SUM_W-1:0]         charge_total;
        logic [CHARGE_W-1:0]      charge_peak;
        logic [SENSOR_W-1:0]      charge_peak_sensor;
        logic signed [TIME_W-1:0] earliest_time;
        logic [SENSOR_W-1:0]      earliest_sensor;
        logic signed [TIME_W-1:0] latest_time;
        logic [SENSOR_W-1:0]      latest_sensor;
    } t_result;

endpackage

`default_nettype wire

[src/hges_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module hges_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [hges_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [hges_pkg::TIME_W-1:0]       i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire [hges_pkg::TIME_W-1:0]       i_hit_time,
    input  wire [hges_pkg::RAW_W-1:0]        i_charge_raw,
    input  wire [hges_pkg::SENSOR_W-1:0]     i_sensor_id,
    input  wire                              i_last,
    output logic                             o_valid,
    input  wire                              i_ready,
    output hges_pkg::t_hit                   o_hit
);
    import hges_pkg::*;

    logic signed [TIME_W-1:0] r_time_offset;
    logic signed [TIME_W-1:0] r_gate_low;
    logic signed [TIME_W-1:0] r_gate_high;

    logic                     r_a_valid;
    logic signed [TIME_W-1:0] r_a_time;
    logic [CHARGE_W-1:0]      r_a_charge;
    logic [SENSOR_W-1:0]      r_a_sensor;
    logic                     r_a_last;

    logic                     r_b_valid;
    t_hit                     r_b;

    logic                     w_a_ready;
    logic                     w_b_ready;
    logic signed [TIME_W:0]   w_diff;
    logic signed [TIME_W-1:0] w_sat;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_offset <= '0;
            r_gate_low    <= '0;
            r_gate_high   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TIME_OFFSET: r_time_offset <= i_cfg_data;
                CFG_GATE_LOW:    r_gate_low    <= i_cfg_data;
                CFG_GATE_HIGH:   r_gate_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stall chain, stage b drains into the queue
    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;
    assign o_valid   = r_b_valid;
    assign o_hit     = r_b;

    // offset subtract with saturation to 32 bits
    assign w_diff = {i_hit_time[TIME_W-1], i_hit_time}
                  - {r_time_offset[TIME_W-1], r_time_offset};

    always_comb begin
        if (w_diff[TIME_W] != w_diff[TIME_W-1]) begin
            w_sat = w_diff[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
        end else begin
            w_sat = w_diff[TIME_W-1:0];
        end
    end

    // stage a: shifted time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_time   <= w_sat;
            r_a_charge <= i_charge_raw[CHARGE_W-1:0];
            r_a_sensor <= i_sensor_id;
            r_a_last   <= i_last;
        end
    end

    // stage b: gate test
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready && r_a_valid) begin
            r_b.in_gate      <= (r_a_time >= r_gate_low) && (r_a_time <= r_gate_high);
            r_b.shifted_time <= r_a_time;
            r_b.charge       <= r_a_charge;
            r_b.sensor       <= r_a_sensor;
            r_b.last         <= r_a_last;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_b_hold, i_clk, i_rst_n, r_b_valid && !i_ready, r_b_valid && $stable(r_b), "stalled hit changed in stage b")
    `ASSERT_NEXT(a_a_hold, i_clk, i_rst_n, r_a_valid && !w_b_ready, r_a_valid && $stable(r_a_time), "stalled hit changed in stage a")

endmodule

`default_nettype wire

[src/hges_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module hges_fifo #(
    parameter int DEPTH = hges_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    output logic             o_ready,
    input  hges_pkg::t_hit   i_hit,
    output logic             o_valid,
    input  wire              i_pop,
    output hges_pkg::t_hit   o_hit
);
    import hges_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_hit            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_hit   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_hit;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_fifo_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue fill above depth")
    `ASSERT_NEXT(a_fifo_grow, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "queue fill did not grow on push")

endmodule

`default_nettype wire

[src/hges_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module hges_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  hges_pkg::t_hit      i_hit,
    output logic                o_valid,
    input  wire                 i_ready,
    output hges_pkg::t_result   o_result
);
    import hges_pkg::*;

    logic [COUNT_W-1:0]       r_hit_count;
    logic [SUM_W-1:0]         r_charge_sum;
    logic [CHARGE_W-1:0]      r_peak_charge;
    logic [SENSOR_W-1:0]      r_peak_sensor;
    logic signed [TIME_W-1:0] r_min_time;
    logic [SENSOR_W-1:0]      r_min_sensor;
    logic signed [TIME_W-1:0] r_max_time;
    logic [SENSOR_W-1:0]      r_max_sensor;

    logic [COUNT_W-1:0]       n_hit_count;
    logic [SUM_W-1:0]         n_charge_sum;
    logic [CHARGE_W-1:0]      n_peak_charge;
    logic [SENSOR_W-1:0]      n_peak_sensor;
    logic signed [TIME_W-1:0] n_min_time;
    logic [SENSOR_W-1:0]      n_min_sensor;
    logic signed [TIME_W-1:0] n_max_time;
    logic [SENSOR_W-1:0]      n_max_sensor;

    logic                     r_out_valid;
    t_result                  r_out;
    logic                     w_pop;
    logic [SUM_W:0]           w_sum;

    // output register frees when empty or taken
    assign o_ready  = !r_out_valid || i_ready;
    assign w_pop    = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign w_sum = {1'b0, r_charge_sum} + {{(SUM_W + 1 - CHARGE_W){1'b0}}, i_hit.charge};

    // statistics update for an in-gate hit
    always_comb begin
        n_hit_count   = r_hit_count;
        n_charge_sum  = r_charge_sum;
        n_peak_charge = r_peak_charge;
        n_peak_sensor = r_peak_sensor;
        n_min_time    = r_min_time;
        n_min_sensor  = r_min_sensor;
        n_max_time    = r_max_time;
        n_max_sensor  = r_max_sensor;
        if (i_hit.in_gate) begin
            if (r_hit_count != {COUNT_W{1'b1}}) begin
                n_hit_count = r_hit_count + 1'b1;
            end
            n_charge_sum = w_sum[SUM_W] ? {SUM_W{1'b1}} : w_sum[SUM_W-1:0];
            if (i_hit.charge > r_peak_charge) begin
                n_peak_charge = i_hit.charge;
                n_peak_sensor = i_hit.sensor;
            end
            if (i_hit.shifted_time < r_min_time) begin
                n_min_time   = i_hit.shifted_time;
                n_min_sensor = i_hit.sensor;
            end
            if (i_hit.shifted_time > r_max_time) begin
                n_max_time   = i_hit.shifted_time;
                n_max_sensor = i_hit.sensor;
            end
        end
    end

    // running statistics, cleared after the last hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_pop && i_hit.last)) begin
            r_hit_count   <= '0;
            r_charge_sum  <= '0;
            r_peak_charge <= '0;
            r_peak_sensor <= '0;
            r_min_time    <= MIN_TIME_INIT;
            r_min_sensor  <= '0;
            r_max_time    <= '0;
            r_max_sensor  <= '0;
        end else if (w_pop) begin
            r_hit_count   <= n_hit_count;
            r_charge_sum  <= n_charge_sum;
            r_peak_charge <= n_peak_charge;
            r_peak_sensor <= n_peak_sensor;
            r_min_time    <= n_min_time;
            r_min_sensor  <= n_min_sensor;
            r_max_time    <= n_max_time;
            r_max_sensor  <= n_max_sensor;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // result payload, summary only on the last hit
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out.in_gate      <= i_hit.in_gate;
            r_out.shifted_time <= i_hit.shifted_time;
            r_out.slot_index   <= i_hit.in_gate ? r_hit_count : '0;
            r_out.event_end    <= i_hit.last;
            if (i_hit.last) begin
                r_out.gate_hit_count     <= n_hit_count;
                r_out.charge_total       <= n_charge_sum;
                r_out.charge_peak        <= n_peak_charge;
                r_out.charge_peak_sensor <= n_peak_sensor;
                r_out.earliest_time      <= n_min_time;
                r_out.earliest_sensor    <= n_min_sensor;
                r_out.latest_time        <= n_max_time;
                r_out.latest_sensor      <= n_max_sensor;
            end else begin
                r_out.gate_hit_count     <= '0;
                r_out.charge_total       <= '0;
                r_out.charge_peak        <= '0;
                r_out.charge_peak_sensor <= '0;
                r_out.earliest_time      <= '0;
                r_out.earliest_sensor    <= '0;
                r_out.latest_time        <= '0;
                r_out.latest_sensor      <= '0;
            end
        end
    end

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_stats_clear, i_clk, i_rst_n, w_pop && i_hit.last, (r_hit_count == '0) && (r_min_time == MIN_TIME_INIT) && (r_max_time == '0), "statistics not cleared after event end")
    `ASSERT_ALWAYS(a_summary_zero, i_clk, i_rst_n, !(r_out_valid && !r_out.event_end) || ((r_out.gate_hit_count == '0) && (r_out.charge_total == '0)), "summary present on a hit that is not last")

endmodule

`default_nettype wire

[src/hit_gate_event_summary.sv]
// a hit accepted on s_axis passes front stages a and b, the queue and the output
// register to m_axis; one hit per cycle while the queue has room; statistics
// update on each popped hit; a 4-entry queue between gate front end and statistics
// back end absorbs output stalls, so s_axis keeps accepting while a result waits
// reset (i_rst_n low, synchronous): config registers to 0, statistics cleared,
// queue and output empty; no clearing pass, hits are accepted right after reset
`timescale 1ns / 1ps
`default_nettype none

module hit_gate_event_summary #(
    parameter int QUEUE_DEPTH = hges_pkg::QUEUE_DEPTH
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration write channel
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [hges_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [hges_pkg::TIME_W-1:0]      i_cfg_data,
    // hit stream in
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // hit_time[31:0], charge_raw[47:32], sensor_id[61:48], zero pad[63:62]
    input  wire [63:0]                      s_axis_tdata,
    input  wire                             s_axis_tlast,
    // result stream out
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // shifted_time[31:0], slot_index[45:32], gate_hit_count[59:46],
    // charge_total[84:60], charge_peak[95:85], charge_peak_sensor[109:96],
    // earliest_time[141:110], earliest_sensor[155:142], latest_time[187:156],
    // latest_sensor[201:188], zero pad[207:202]
    output logic [207:0]                    m_axis_tdata,
    // in_gate[0]
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import hges_pkg::*;

    logic    w_q_push;
    logic    w_q_ready;
    t_hit    w_q_in;
    logic    w_q_valid;
    logic    w_q_pop;
    t_hit    w_q_out;
    t_result w_res;

    // gate front end
    hges_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_hit_time   (s_axis_tdata[31:0]),
        .i_charge_raw (s_axis_tdata[47:32]),
        .i_sensor_id  (s_axis_tdata[61:48]),
        .i_last       (s_axis_tlast),
        .o_valid      (w_q_push),
        .i_ready      (w_q_ready),
        .o_hit        (w_q_in)
    );

    // decoupling queue
    hges_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .o_ready (w_q_ready),
        .i_hit   (w_q_in),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_hit   (w_q_out)
    );

    // statistics back end
    hges_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_pop),
        .i_hit    (w_q_out),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    // result packing
    assign m_axis_tdata = {6'd0,
                           w_res.latest_sensor,
                           w_res.latest_time,
                           w_res.earliest_sensor,
                           w_res.earliest_time,
                           w_res.charge_peak_sensor,
                           w_res.charge_peak,
                           w_res.charge_total,
                           w_res.gate_hit_count,
                           w_res.slot_index,
                           w_res.shifted_time};
    assign m_axis_tuser = w_res.in_gate;
    assign m_axis_tlast = w_res.event_end;

endmodule

`default_nettype wire

[tb/hit_gate_event_summary_test.sv]
`timescale 1ns / 1ps

module hit_gate_event_summary_test;
    import hges_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_HITS   = 150;
    localparam int LONG_HITS    = 40;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [TIME_W-1:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [TIME_W-1:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic [COUNT_W-1:0]       COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]         SUM_MAX = '1;

    // running event statistics and the results they lead to
    class event_summary_tracker;
        logic signed [TIME_W-1:0] time_offset, gate_low, gate_high;
        logic [COUNT_W-1:0]       hit_count;
        logic [SUM_W-1:0]         charge_sum;
        logic [CHARGE_W-1:0]      peak_charge;
        logic [SENSOR_W-1:0]      peak_sensor, min_sensor, max_sensor;
        logic signed [TIME_W-1:0] min_time, max_time;
        t_result                  pending_results[$];
        int mismatches, results_checked, hits_noted, gated_hits, events_closed;

        function new();
            time_offset = '0;
            gate_low = '0;
            gate_high = '0;
            mismatches = 0;
            results_checked = 0;
            hits_noted = 0;
            gated_hits = 0;
            events_closed = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            hit_count = '0;
            charge_sum = '0;
            peak_charge = '0;
            peak_sensor = '0;
            min_time = MIN_TIME_INIT;
            min_sensor = '0;
            max_time = '0;
            max_sensor = '0;
        endfunction

        function void write_register(t_cfg_index index, logic [TIME_W-1:0] value);
            case (index)
                CFG_TIME_OFFSET: time_offset = value;
                CFG_GATE_LOW:    gate_low = value;
                CFG_GATE_HIGH:   gate_high = value;
                default: ;
            endcase
        endfunction

        // one accepted hit request: gate it, update the statistics, queue its result
        function void note_hit(logic signed [TIME_W-1:0] hit_time, logic [RAW_W-1:0] charge_raw,
                               logic [SENSOR_W-1:0] sensor, logic last);
            longint                   shifted_wide;
            logic signed [TIME_W-1:0] shifted;
            logic [CHARGE_W-1:0]      charge;
            logic [SUM_W:0]           sum_wide;
            t_result                  want;
            shifted_wide = longint'(hit_time) - longint'(time_offset);
            if (shifted_wide > longint'(T_MAX)) shifted_wide = longint'(T_MAX);
            if (shifted_wide < longint'(T_MIN)) shifted_wide = longint'(T_MIN);
            shifted = shifted_wide[TIME_W-1:0];
            charge = charge_raw[CHARGE_W-1:0];
            want = '0;
            want.in_gate = (shifted >= gate_low) && (shifted <= gate_high);
            want.shifted_time = shifted;
            want.event_end = last;
            if (want.in_gate) begin
                gated_hits++;
                want.slot_index = hit_count;
                if (hit_count != COUNT_MAX) hit_count++;
                sum_wide = {1'b0, charge_sum} + (SUM_W+1)'(charge);
                charge_sum = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
                // strict compares so that the first sensor wins a tie
                if (charge > peak_charge) begin
                    peak_charge = charge;
                    peak_sensor = sensor;
                end
                if (min_time > shifted) begin
                    min_time = shifted;
                    min_sensor = sensor;
                end
                if (max_time < shifted) begin
                    max_time = shifted;
                    max_sensor = sensor;
                end
            end
            if (last) begin
                want.gate_hit_count = hit_count;
                want.charge_total = charge_sum;
                want.charge_peak = peak_charge;
                want.charge_peak_sensor = peak_sensor;
                want.earliest_time = min_time;
                want.earliest_sensor = min_sensor;
                want.latest_time = max_time;
                want.latest_sensor = max_sensor;
                events_closed++;
                clear_stats();
            end
            pending_results.push_back(want);
            hits_noted++;
        endfunction

        function void compare_field(string field, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d: %s expected %h, got %h",
                             results_checked, field, want, got);
            end
        endfunction

        // one accepted result request against the oldest pending one
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result with nothing pending: shifted_time %h", got.shifted_time);
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            compare_field("in_gate", want.in_gate, got.in_gate);
            compare_field("shifted_time", want.shifted_time, got.shifted_time);
            compare_field("slot_index", want.slot_index, got.slot_index);
            compare_field("event_end", want.event_end, got.event_end);
            compare_field("gate_hit_count", want.gate_hit_count, got.gate_hit_count);
            compare_field("charge_total", want.charge_total, got.charge_total);
            compare_field("charge_peak", want.charge_peak, got.charge_peak);
            compare_field("charge_peak_sensor", want.charge_peak_sensor, got.charge_peak_sensor);
            compare_field("earliest_time", want.earliest_time, got.earliest_time);
            compare_field("earliest_sensor", want.earliest_sensor, got.earliest_sensor);
            compare_field("latest_time", want.latest_time, got.latest_time);
            compare_field("latest_sensor", want.latest_sensor, got.latest_sensor);
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    t_cfg_index   i_cfg_index = CFG_TIME_OFFSET;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [207:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    event_summary_tracker board = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    logic signed [TIME_W-1:0] cur_offset = '0, cur_low = '0, cur_high = '0;
    logic [TIME_W-1:0]        recent_time = '0;
    logic [RAW_W-1:0]         recent_charge = '0;

    hit_gate_event_summary u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // result side: check accepted results, then stall, hold off or accept
    always @(posedge i_clk) begin
        t_result got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.in_gate = m_axis_tuser;
            got.shifted_time = m_axis_tdata[31:0];
            got.slot_index = m_axis_tdata[45:32];
            got.event_end = m_axis_tlast;
            got.gate_hit_count = m_axis_tdata[59:46];
            got.charge_total = m_axis_tdata[84:60];
            got.charge_peak = m_axis_tdata[95:85];
            got.charge_peak_sensor = m_axis_tdata[109:96];
            got.earliest_time = m_axis_tdata[141:110];
            got.earliest_sensor = m_axis_tdata[155:142];
            got.latest_time = m_axis_tdata[187:156];
            got.latest_sensor = m_axis_tdata[201:188];
            board.check_result(got);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no request moving anywhere
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: nothing accepted for %0d cycles, %0d results still pending",
                 STALL_LIMIT, board.pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // one hit request, after a random gap; valid stays up for a following hit
    task automatic send_hit(input logic [31:0] hit_time, input logic [15:0] charge_raw,
                            input logic [13:0] sensor, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, sensor, charge_raw, hit_time};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_hit(hit_time, charge_raw, sensor, last);
    endtask

    // drop valid and let every pending result drain out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers back to back
    task automatic configure(input logic [31:0] offset, input logic [31:0] low,
                             input logic [31:0] high);
        t_cfg_index  order [3] = '{CFG_TIME_OFFSET, CFG_GATE_LOW, CFG_GATE_HIGH};
        logic [31:0] values [3];
        values[0] = offset;
        values[1] = low;
        values[2] = high;
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data <= values[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            board.write_register(order[k], values[k]);
        end
        i_cfg_valid <= 1'b0;
        cur_offset = offset;
        cur_low = low;
        cur_high = high;
    endtask

    // hit times mostly around the gate, with edges, repeats for ties and pure noise
    function automatic logic [31:0] pick_hit_time();
        longint      lo, hi, span, target;
        logic [31:0] pick;
        lo = longint'(cur_low);
        hi = longint'(cur_high);
        case ($urandom_range(0, 19))
            0, 1: pick = $urandom;
            2: pick = 32'(lo + longint'(cur_offset));
            3: pick = 32'(hi + longint'(cur_offset));
            4: pick = recent_time;
            default: begin
                if (hi < lo) begin
                    lo = lo - 32;
                    span = 64;
                end else begin
                    lo = lo - 4;
                    span = hi - lo + 5;
                end
                target = lo + longint'({$urandom, $urandom} % 64'(span));
                pick = 32'(target + longint'(cur_offset));
            end
        endcase
        recent_time = pick;
        return pick;
    endfunction

    function automatic logic [15:0] pick_charge();
        logic [15:0] pick;
        case ($urandom_range(0, 9))
            0: pick = recent_charge;
            1: pick = {5'($urandom), 11'h7FF};
            2: pick = {5'($urandom), 11'h000};
            default: pick = 16'($urandom);
        endcase
        recent_charge = pick;
        return pick;
    endfunction

    function automatic logic [13:0] pick_sensor();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return 14'($urandom_range(0, 16383));
        endcase
    endfunction

    // one idling mix and one gate setting, whole events of random length
    task automatic run_phase(input int send_pct, input int recv_pct, input logic [31:0] offset,
                             input logic [31:0] low, input logic [31:0] high, input int hits);
        int sent;
        int len;
        wait_idle();
        recv_stall_pct <= recv_pct;
        send_idle_pct = send_pct;
        configure(offset, low, high);
        sent = 0;
        while (sent < hits) begin
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
            for (int k = 0; k < len; k++)
                send_hit(pick_hit_time(), pick_charge(), pick_sensor(), k == len - 1);
            sent += len;
        end
    endtask

    function automatic logic [31:0] random_gate_low();
        return 32'($urandom_range(0, 4000)) - 32'd2000;
    endfunction

    initial begin
        logic [31:0] low;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // gate edges, ties, out-of-gate hits and time overflow
        configure(32'd1000, -32'sd50, 32'sd500);
        send_hit(32'd1000, 16'hFFFF, 14'd1, 1'b0);
        send_hit(32'd1500, 16'h07FF, 14'd2, 1'b0);
        send_hit(32'd950, 16'h0005, 14'd3, 1'b0);
        send_hit(32'd949, 16'hFFFF, 14'd4, 1'b0);
        send_hit(32'd1501, 16'h0000, 14'd5, 1'b0);
        send_hit(32'd950, 16'h0100, 14'd6, 1'b0);
        send_hit(32'd1500, 16'h0100, 14'd7, 1'b0);
        send_hit(T_MAX, 16'h0000, 14'h3FFF, 1'b0);
        send_hit(T_MIN, 16'hAAAA, 14'h0000, 1'b1);
        // event with nothing in the gate, then one with negative times only
        send_hit(32'd1600, 16'h5555, 14'h2AAA, 1'b1);
        send_hit(32'd900, 16'h1234, 14'd9, 1'b0);
        send_hit(32'd960, 16'h0001, 14'h1555, 1'b1);

        // full gate with the largest offset: saturation low, negative times
        wait_idle();
        configure(T_MAX, T_MIN, T_MAX);
        send_hit(T_MIN, 16'h07FF, 14'd10, 1'b0);
        send_hit(32'd0, 16'h07FF, 14'd11, 1'b0);
        send_hit(T_MAX, 16'h0000, 14'd12, 1'b1);

        // empty gate with the smallest offset: saturation high
        wait_idle();
        configure(T_MIN, 32'sd10, -32'sd10);
        send_hit(T_MAX, 16'h07FF, 14'd13, 1'b0);
        send_hit(T_MIN, 16'h07FF, 14'd14, 1'b0);
        send_hit(32'd0, 16'h0400, 14'd15, 1'b1);

        // random events under each idling mix
        low = random_gate_low();
        run_phase(0, 0, $urandom, low, low + $urandom_range(0, 4000) - 300, PHASE_HITS);

        // one long event of large charges, all inside the gate
        wait_idle();
        configure($urandom, -32'sd100, 32'sd100);
        for (int k = 0; k < LONG_HITS; k++)
            send_hit(32'(longint'(cur_offset) + $urandom_range(0, 200) - 100),
                     {5'($urandom), 7'h7F, 4'($urandom)}, 14'($urandom), k == LONG_HITS - 1);

        low = random_gate_low();
        run_phase(52, 0, $urandom, low, low + $urandom_range(0, 4000) - 300, PHASE_HITS);

        // long receiver hold-off while hits keep coming, so the input backs up
        wait_idle();
        hold_requests <= hold_requests + 1;
        run_phase(0, 52, 32'd0, T_MIN, T_MAX, PHASE_HITS);

        low = random_gate_low();
        run_phase(35, 35, $urandom, low, low + $urandom_range(0, 4000) - 300, PHASE_HITS);
        run_phase(35, 35, T_MIN, 32'd0, T_MAX, 80);
        wait_idle();

        $display("sent %0d hits in %0d events, %0d inside the gate, %0d results checked",
                 board.hits_noted, board.events_closed, board.gated_hits,
                 board.results_checked);
        $display("covered gate edges, ties, time saturation, empty and full gates, %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
